@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared types for the free-list allocator
// sequencer states
// ----------------------------------------------------------------------------
package ffa_pkg;

  // arena geometry: unit count and bytes per header unit (a power of two)
  localparam int ArenaUnits = 4096;
  localparam int UnitBytes  = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RDLINK0,   // read link of rover
    ST_A_RDSIZE,    // read size and link of w
    ST_A_CHECK,     // decide fit
    ST_A_SPLIT,     // write header of tail
    ST_A_RESUME,    // reread link of the new rover after growth
    ST_G_START,     // growth claim
    ST_F_RDLINK,    // free walk: read link of w
    ST_F_CHECK,
    ST_F_RDHDR,     // read size of hdr
    ST_F_RDN,       // read size and link of n
    ST_F_MERGEHI,
    ST_F_RDW,       // read size of w
    ST_F_RDHDR2,    // reread hdr size and link
    ST_F_MERGELO,
    ST_RESP
  } state_e;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;
  localparam logic [1:0] RegGrowMin = 2'd0;

endpackage

@@ rtl/first_fit_free_list_allocator_top.sv @@
// an allocate reads the rover link, then the size and link of each block visited up to a
// fit, and writes a tail header for a split; a growth claims at the heap top, walks the
// free list, merges and resumes the walk; a free walks the free list, then merges
// throughput: one transaction at a time, not ready again until the result is taken
// reset: rover 0, heap top 1, grow minimum 1024, sentinel entry 0 reads as zero
// store entries other than the sentinel are undefined until written
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// next-fit allocator over a header-unit arena with address-ordered free list
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: request_bytes[15:0], block_address[27:16], zero pad; tuser: kind
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  // tdata: payload_address[11:0], ok[12], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ARENA_UNITS = ffa_pkg::ArenaUnits;
  localparam int UNIT_BYTES  = ffa_pkg::UnitBytes;
  localparam int AW = $clog2(ARENA_UNITS);      // store index width
  localparam int UW = AW + 1;                   // unit counts up to ARENA_UNITS
  localparam int WW = UW + 2;                   // working width with headroom
  localparam int SHIFT = $clog2(UNIT_BYTES);
  localparam int SCW = $clog2(3 * ARENA_UNITS + 10);
  localparam logic [WW-1:0] ArenaW = WW'(ARENA_UNITS);

  // store memories: size and link per header
  logic [UW-1:0] size_mem [ARENA_UNITS];
  logic [AW-1:0] link_mem [ARENA_UNITS];
  logic [UW-1:0] size_rd_q;
  logic [AW-1:0] link_rd_q;
  logic [AW-1:0] rd_addr;
  logic          sz_we, ln_we;
  logic [AW-1:0] sz_wa, ln_wa;
  logic [UW-1:0] sz_wd;
  logic [AW-1:0] ln_wd;
  // sentinel cleared at reset: one flag per store marks entry 0 as written
  logic          zero_sz_q, zero_ln_q;

  always_ff @(posedge clk_i) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (ln_we) link_mem[ln_wa] <= ln_wd;
    size_rd_q <= size_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
  end

  logic rd_zsz_q, rd_zln_q;
  logic [UW-1:0] size_rd;
  logic [AW-1:0] link_rd;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_sz_q <= 1'b0;
      zero_ln_q <= 1'b0;
      rd_zsz_q <= 1'b0;
      rd_zln_q <= 1'b0;
    end else begin
      rd_zsz_q <= (rd_addr == '0) && !zero_sz_q;
      rd_zln_q <= (rd_addr == '0) && !zero_ln_q;
      if (sz_we && sz_wa == '0) zero_sz_q <= 1'b1;
      if (ln_we && ln_wa == '0) zero_ln_q <= 1'b1;
    end
  end
  // entry zero of each store reads as zero until that store writes it
  assign size_rd = rd_zsz_q ? '0 : size_rd_q;
  assign link_rd = rd_zln_q ? '0 : link_rd_q;

  // configuration register
  logic [12:0] grow_min_q;
  assign pready = 1'b1;
  assign prdata = (paddr == ffa_pkg::RegGrowMin) ? {19'd0, grow_min_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) grow_min_q <= 13'd1024;
    else if (psel && penable && pwrite && paddr == ffa_pkg::RegGrowMin)
      grow_min_q <= pwdata[12:0];
  end

  // sequencer state
  ffa_pkg::state_e state_q, state_d;
  logic [AW-1:0] rover_q, rover_d;
  logic [WW-1:0] top_q, top_d;
  logic [WW-1:0] units_q, units_d;
  logic [AW-1:0] prev_q, prev_d, w_q, w_d, hdr_q, hdr_d, n_q, n_d;
  logic [UW-1:0] s_q, s_d, hs_q, hs_d, ns_q, ns_d;
  logic [AW-1:0] nl_q, nl_d;
  logic [SCW-1:0] steps_q, steps_d;      // free-walk steps
  logic [SCW-1:0] astep_q, astep_d;      // allocate-walk steps, kept across growth
  logic          growing_q, growing_d;   // free is part of a growth
  logic [AW-1:0] pay_q, pay_d;
  logic          ok_q, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::ST_IDLE;
      rover_q <= '0;
      top_q <= WW'(1);
      steps_q <= '0;
      astep_q <= '0;
      growing_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rover_q <= rover_d;
      top_q <= top_d;
      steps_q <= steps_d;
      astep_q <= astep_d;
      growing_q <= growing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q <= units_d; prev_q <= prev_d; w_q <= w_d; hdr_q <= hdr_d; n_q <= n_d;
    s_q <= s_d; hs_q <= hs_d; ns_q <= ns_d; nl_q <= nl_d;
    pay_q <= pay_d; ok_q <= ok_d;
  end

  // units needed: ceil(bytes / UNIT_BYTES) + 1
  logic [WW-1:0] req_units;
  logic [16:0]   bytes_up;
  assign bytes_up = {1'b0, s_axis_tdata_i[15:0]} + 17'(UNIT_BYTES - 1);
  assign req_units = WW'(bytes_up >> SHIFT) + WW'(1);

  logic [WW-1:0] claim;
  assign claim = (units_q < WW'(grow_min_q)) ? WW'(grow_min_q) : units_q;

  assign s_axis_tready_o = (state_q == ffa_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ffa_pkg::ST_RESP);
  assign m_axis_tdata_o  = {3'd0, ok_q, 12'(pay_q)};

  // a shared adder: used as a sum or a difference per state
  logic [WW-1:0] add_a, add_b, add_y;
  logic          add_sub;
  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_comb begin
    state_d = state_q; rover_d = rover_q; top_d = top_q; units_d = units_q;
    prev_d = prev_q; w_d = w_q; hdr_d = hdr_q; n_d = n_q; s_d = s_q; hs_d = hs_q;
    ns_d = ns_q; nl_d = nl_q; steps_d = steps_q; astep_d = astep_q;
    growing_d = growing_q; pay_d = pay_q; ok_d = ok_q;
    rd_addr = w_q; sz_we = 1'b0; ln_we = 1'b0; sz_wa = w_q; ln_wa = w_q;
    sz_wd = '0; ln_wd = '0;
    add_a = '0; add_b = '0; add_sub = 1'b0;
    case (state_q)
      ffa_pkg::ST_IDLE: begin
        steps_d = '0;
        astep_d = '0;
        if (s_axis_tvalid_i) begin
          pay_d = '0; ok_d = 1'b1; growing_d = 1'b0;
          if (s_axis_tuser_i == ffa_pkg::KindAlloc) begin
            units_d = req_units;
            prev_d = rover_q;
            rd_addr = rover_q;
            state_d = ffa_pkg::ST_A_RDLINK0;
          end else if (s_axis_tdata_i[27:16] == 12'd0) begin
            state_d = ffa_pkg::ST_RESP;
          end else begin
            add_a = WW'(s_axis_tdata_i[27:16]); add_b = WW'(1); add_sub = 1'b1;
            hdr_d = AW'(add_y);
            w_d = rover_q;
            state_d = (add_y >= ArenaW) ? ffa_pkg::ST_RESP : ffa_pkg::ST_F_RDLINK;
          end
        end
      end
      ffa_pkg::ST_A_RDLINK0: begin
        w_d = link_rd;
        state_d = ffa_pkg::ST_A_RDSIZE;
      end
      ffa_pkg::ST_A_RDSIZE: begin
        rd_addr = w_q;
        state_d = ffa_pkg::ST_A_CHECK;
      end
      ffa_pkg::ST_A_CHECK: begin
        s_d = size_rd;
        if (WW'(size_rd) >= units_q) begin
          rover_d = prev_q;
          if (WW'(size_rd) == units_q) begin
            ln_we = 1'b1; ln_wa = prev_q; ln_wd = link_rd;
            add_a = WW'(w_q); add_b = WW'(1);
            pay_d = AW'(add_y);
            state_d = ffa_pkg::ST_RESP;
          end else begin
            add_a = WW'(size_rd); add_b = units_q; add_sub = 1'b1;
            sz_we = 1'b1; sz_wa = w_q; sz_wd = UW'(add_y);
            s_d = UW'(add_y);
            state_d = ffa_pkg::ST_A_SPLIT;
          end
        end else if (w_q == rover_q) begin
          state_d = ffa_pkg::ST_G_START;
        end else begin
          prev_d = w_q; w_d = link_rd;
          astep_d = astep_q + SCW'(1);
          if (astep_q + SCW'(1) > SCW'(3 * ARENA_UNITS + 8)) begin
            ok_d = 1'b0; state_d = ffa_pkg::ST_RESP;
          end else begin
            state_d = ffa_pkg::ST_A_RDSIZE;
          end
        end
      end
      ffa_pkg::ST_A_SPLIT: begin
        add_a = WW'(w_q); add_b = WW'(s_q);
        // a tail header beyond the arena is not stored
        sz_we = (add_y < ArenaW); sz_wa = AW'(add_y); sz_wd = UW'(units_q);
        pay_d = AW'(add_y + WW'(1));
        state_d = ffa_pkg::ST_RESP;
      end
      ffa_pkg::ST_A_RESUME: begin
        rd_addr = prev_q;
        state_d = ffa_pkg::ST_A_RDLINK0;
      end
      ffa_pkg::ST_G_START: begin
        add_a = ArenaW; add_b = top_q; add_sub = 1'b1;
        if (top_q > ArenaW || claim > add_y) begin
          ok_d = 1'b0; pay_d = '0; state_d = ffa_pkg::ST_RESP;
        end else begin
          sz_we = 1'b1; sz_wa = AW'(top_q); sz_wd = UW'(claim);
          top_d = top_q + claim;
          hdr_d = AW'(top_q);
          growing_d = 1'b1;
          w_d = rover_q;
          steps_d = '0;
          state_d = ffa_pkg::ST_F_RDLINK;
        end
      end
      ffa_pkg::ST_F_RDLINK: begin
        rd_addr = w_q;
        state_d = ffa_pkg::ST_F_CHECK;
      end
      ffa_pkg::ST_F_CHECK: begin
        if ((hdr_q > w_q && hdr_q < link_rd) ||
            (w_q >= link_rd && (hdr_q > w_q || hdr_q < link_rd))) begin
          n_d = link_rd;
          rd_addr = hdr_q;
          state_d = ffa_pkg::ST_F_RDHDR;
        end else begin
          w_d = link_rd;
          steps_d = steps_q + SCW'(1);
          if (steps_q + SCW'(1) > SCW'(ARENA_UNITS + 2)) begin
            // no slot found: release dropped, a growth walks on from the rover
            steps_d = '0;
            rd_addr = rover_q;
            if (growing_q) begin
              growing_d = 1'b0;
              w_d = w_q; prev_d = rover_q;
              astep_d = astep_q + SCW'(1);
              if (astep_q + SCW'(1) > SCW'(3 * ARENA_UNITS + 8)) begin
                ok_d = 1'b0; state_d = ffa_pkg::ST_RESP;
              end else begin
                state_d = ffa_pkg::ST_A_RDLINK0;
              end
            end else begin
              state_d = ffa_pkg::ST_RESP;
            end
          end else begin
            state_d = ffa_pkg::ST_F_RDLINK;
          end
        end
      end
      ffa_pkg::ST_F_RDHDR: begin
        hs_d = size_rd;
        rd_addr = n_q;
        state_d = ffa_pkg::ST_F_RDN;
      end
      ffa_pkg::ST_F_RDN: begin
        ns_d = size_rd; nl_d = link_rd;
        state_d = ffa_pkg::ST_F_MERGEHI;
      end
      ffa_pkg::ST_F_MERGEHI: begin
        add_a = WW'(hdr_q); add_b = WW'(hs_q);
        ln_we = 1'b1; ln_wa = hdr_q;
        if (add_y == WW'(n_q)) begin
          sz_we = 1'b1; sz_wa = hdr_q; sz_wd = hs_q + ns_q;
          ln_wd = nl_q;
        end else begin
          ln_wd = n_q;
        end
        state_d = ffa_pkg::ST_F_RDW;
      end
      ffa_pkg::ST_F_RDW: begin
        rd_addr = w_q;
        state_d = ffa_pkg::ST_F_RDHDR2;
      end
      ffa_pkg::ST_F_RDHDR2: begin
        s_d = size_rd;
        rd_addr = hdr_q;
        state_d = ffa_pkg::ST_F_MERGELO;
      end
      ffa_pkg::ST_F_MERGELO: begin
        add_a = WW'(w_q); add_b = WW'(s_q);
        ln_we = 1'b1; ln_wa = w_q;
        if (add_y == WW'(hdr_q)) begin
          sz_we = 1'b1; sz_wa = w_q; sz_wd = s_q + size_rd;
          ln_wd = link_rd;
        end else begin
          ln_wd = hdr_q;
        end
        rover_d = w_q;
        if (growing_q) begin
          // walk on from the new rover: prev = rover, w = link(rover)
          growing_d = 1'b0;
          prev_d = w_q;
          astep_d = astep_q + SCW'(1);
          if (astep_q + SCW'(1) > SCW'(3 * ARENA_UNITS + 8)) begin
            ok_d = 1'b0; state_d = ffa_pkg::ST_RESP;
          end else begin
            state_d = ffa_pkg::ST_A_RESUME;
          end
        end else begin
          state_d = ffa_pkg::ST_RESP;
        end
      end
      ffa_pkg::ST_RESP: begin
        if (m_axis_tready_i) state_d = ffa_pkg::ST_IDLE;
      end
      default: state_d = ffa_pkg::ST_IDLE;
    endcase
    // link of prev is reread while its value is taken from the previous read
    if (state_q == ffa_pkg::ST_A_RDLINK0) rd_addr = prev_q;
  end

endmodule

@@ bench/ffa_checker.sv @@
// ----------------------------------------------------------------------------
// ffa_checker: allocator response checker
// keeps its own copy of the arena state, predicts each grant and compares
// ----------------------------------------------------------------------------
module ffa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          err_count_o,
  output int          pending_o
);

  localparam int unsigned Arena = 4096;
  localparam int unsigned UnitBytes = 16;

  typedef struct packed {
    logic [11:0] payload;
    logic        ok;
  } grant_t;

  bit [12:0]   size_mem [Arena];
  bit [11:0]   link_mem [Arena];
  int unsigned rover_q;
  int unsigned top_q;
  int unsigned grow_min_q;
  grant_t      expected_grants [$];
  int          mismatches;

  assign err_count_o = mismatches;
  assign pending_o   = expected_grants.size();

  function automatic int unsigned rd_sz(int unsigned i);
    return (i < Arena) ? int'(size_mem[i]) : 0;
  endfunction

  function automatic int unsigned rd_lk(int unsigned i);
    return (i < Arena) ? int'(link_mem[i]) : 0;
  endfunction

  function automatic void wr_sz(int unsigned i, int unsigned v);
    if (i < Arena) size_mem[i] = v[12:0];
  endfunction

  function automatic void wr_lk(int unsigned i, int unsigned v);
    if (i < Arena) link_mem[i] = v[11:0];
  endfunction

  // address-ordered insert with merge on both sides
  function automatic void put_back(int unsigned hdr);
    int unsigned w;
    int unsigned nxt;
    int unsigned steps;
    w = rover_q;
    steps = 0;
    if (hdr == 0 || hdr >= Arena) return;
    forever begin
      nxt = rd_lk(w);
      if (hdr > w && hdr < nxt) break;
      if (w >= nxt && (hdr > w || hdr < nxt)) break;
      w = nxt;
      steps++;
      if (steps > Arena + 2) return;
    end
    nxt = rd_lk(w);
    if (hdr + rd_sz(hdr) == nxt) begin
      wr_sz(hdr, rd_sz(hdr) + rd_sz(nxt));
      wr_lk(hdr, rd_lk(nxt));
    end else begin
      wr_lk(hdr, nxt);
    end
    if (w + rd_sz(w) == hdr) begin
      wr_sz(w, rd_sz(w) + rd_sz(hdr));
      wr_lk(w, rd_lk(hdr));
    end else begin
      wr_lk(w, hdr);
    end
    rover_q = w;
  endfunction

  function automatic bit claim_top(int unsigned units);
    int unsigned nu;
    int unsigned base;
    nu = (units < grow_min_q) ? grow_min_q : units;
    if (top_q > Arena || nu > Arena - top_q) return 1'b0;
    base = top_q;
    wr_sz(base, nu);
    top_q += nu;
    put_back(base);
    return 1'b1;
  endfunction

  function automatic grant_t grant_for(logic kind, logic [15:0] bytes, logic [11:0] addr);
    grant_t      g;
    int unsigned units;
    int unsigned prev;
    int unsigned w;
    int unsigned s;
    int unsigned steps;
    g.payload = '0;
    g.ok = 1'b1;
    if (kind == ffa_pkg::KindFree) begin
      if (addr != 0) put_back(int'(addr) - 1);
      return g;
    end
    units = (int'(bytes) + UnitBytes - 1) / UnitBytes + 1;
    prev = rover_q;
    w = rd_lk(prev);
    steps = 0;
    forever begin
      s = rd_sz(w);
      if (s >= units) begin
        if (s == units) begin
          wr_lk(prev, rd_lk(w));
        end else begin
          wr_sz(w, s - units);
          w += s - units;
          wr_sz(w, units);
        end
        rover_q = prev;
        g.payload = 12'((w + 1) & 32'hfff);
        return g;
      end
      if (w == rover_q) begin
        if (!claim_top(units)) begin
          g.ok = 1'b0;
          return g;
        end
        w = rover_q;
      end
      prev = w;
      w = rd_lk(w);
      steps++;
      if (steps > 3 * Arena + 8) begin
        g.ok = 1'b0;
        return g;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    grant_t got;
    if (!rst_ni) begin
      size_mem[0] = '0;
      link_mem[0] = '0;
      rover_q = 0;
      top_q = 1;
      grow_min_q = 1024;
      expected_grants.delete();
      mismatches = 0;
    end else begin
      // register write completes on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ffa_pkg::RegGrowMin)
        grow_min_q = int'(pwdata_i[12:0]);
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_grants.push_back(grant_for(s_axis_tuser_i, s_axis_tdata_i[15:0],
                                            s_axis_tdata_i[27:16]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.payload = m_axis_tdata_i[11:0];
        got.ok = m_axis_tdata_i[12];
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("checker: unexpected response %h", m_axis_tdata_i);
        end else begin
          exp_g = expected_grants.pop_front();
          if (got.payload !== exp_g.payload || got.ok !== exp_g.ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: payload exp %h got %h, ok exp %b got %b",
                       exp_g.payload, got.payload, exp_g.ok, got.ok);
          end
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: free-list allocator testbench
// directed allocate/free sequences, then random traffic under three idle
// profiles and several growth minimums; the checker predicts every response
// ----------------------------------------------------------------------------
module tb;

  localparam int Limit = 50000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // request_bytes[15:0], block_address[27:16]
  logic        s_axis_tuser_i = 1'b0; // kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // payload_address[11:0], ok[12]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_count;
  int          pending;
  int          cycles = 0;
  int          send_idle = 0;   // percent of idle cycles on the request side
  int          recv_idle = 0;   // percent of stalled cycles on the response side
  logic        sent_kinds [$];  // kind of each request still waiting for its response
  logic [11:0] live [$];        // payload addresses currently held
  int          n_alloc = 0;
  int          n_free = 0;
  int          n_fail = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  first_fit_free_list_allocator_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ffa_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .err_count_o(err_count), .pending_o(pending)
  );

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // response side stalls at random
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  // track granted blocks so frees by index only ever target held blocks
  always @(posedge clk_i) begin
    logic k;
    if (m_axis_tvalid_o && m_axis_tready_i && sent_kinds.size() != 0) begin
      k = sent_kinds.pop_front();
      if (k == ffa_pkg::KindAlloc) begin
        if (!m_axis_tdata_o[12]) n_fail++;
        else if (m_axis_tdata_o[11:0] != 0) live.push_back(m_axis_tdata_o[11:0]);
      end
    end
  end

  // one request transaction; valid stays high into the next one when no gap
  task automatic send_req(logic kind, logic [15:0] bytes, logic [11:0] addr);
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {4'b0, addr, bytes};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_kinds.push_back(kind);
    if (kind == ffa_pkg::KindAlloc) n_alloc++;
    else n_free++;
  endtask

  task automatic alloc_req(logic [15:0] bytes);
    send_req(ffa_pkg::KindAlloc, bytes, 12'($urandom));
  endtask

  // free a held block picked by index, or the newest one
  task automatic free_req(int idx);
    logic [11:0] a;
    a = live[idx];
    live.delete(idx);
    send_req(ffa_pkg::KindFree, 16'($urandom), a);
  endtask

  // wait until every response is in; requests are lowered first
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || sent_kinds.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // apb write: setup then access cycle
  task automatic write_grow_min(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ffa_pkg::RegGrowMin;
    pwdata  <= v;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int items, int sidle, int ridle);
    int p;
    send_idle = sidle;
    recv_idle = ridle;
    for (int i = 0; i < items; i++) begin
      // mid-phase: hold off until everything has come back
      if (i == items / 2) begin
        drain();
      end
      p = $urandom_range(0, 99);
      if (p < 2) begin
        send_req(ffa_pkg::KindFree, 16'($urandom), 12'd0);
      end else if (live.size() != 0 && p < (live.size() > 40 ? 70 : 38)) begin
        free_req($urandom_range(0, live.size() - 1));
      end else if (p < 90) begin
        alloc_req(16'($urandom_range(0, 600)));
      end else if (p < 97) begin
        alloc_req(16'($urandom_range(0, 8000)));
      end else begin
        alloc_req(16'($urandom));
      end
      // stretches without any idling on either side
      if (i % 100 == 50) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (i % 100 == 75) begin
        send_idle = sidle;
        recv_idle = ridle;
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset growth minimum, size extremes and exhaustion
    alloc_req(16'd0);
    alloc_req(16'd1);
    alloc_req(16'd16);
    alloc_req(16'd17);
    alloc_req(16'hffff);
    alloc_req(16'd16000);
    alloc_req(16'd40000);
    drain();
    // free in grant order, then reverse, to merge on both sides
    send_req(ffa_pkg::KindFree, 16'hffff, 12'd0);
    while (live.size() > 2) free_req(0);
    while (live.size() != 0) free_req(live.size() - 1);
    drain();

    // growth minimum at zero: claims exactly the needed units
    write_grow_min(32'd0);
    alloc_req(16'd200);
    alloc_req(16'd0);
    alloc_req(16'd33);
    drain();
    // growth minimum above what is left: growth always fails
    write_grow_min(32'd4096);
    alloc_req(16'd65000);
    alloc_req(16'd60000);
    drain();
    write_grow_min(32'h1fff);
    alloc_req(16'd64000);
    drain();
    while (live.size() != 0) free_req($urandom_range(0, live.size() - 1));
    drain();

    write_grow_min(32'd1);
    random_phase(500, 20, 47);
    write_grow_min(32'($urandom_range(2, 300)));
    random_phase(500, 47, 20);
    write_grow_min(32'd1024);
    random_phase(500, 0, 0);

    repeat (50) @(posedge clk_i);
    $display("tb: %0d allocates (%0d refused), %0d frees, growth minimums 0 to 8191",
             n_alloc, n_fail, n_free);
    $display("tb: three idle profiles, mid-phase hold-offs, %0d cycles", cycles);
    if (err_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
